>>> rtl/core/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, op codes, character tables and segment constants for the
// sms segment counter.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // request op codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_e;

    // input request payload
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] code_unit;
    } in_t;

    // result payload
    typedef struct packed {
        logic [6:0]  message_count;
        logic [7:0]  remaining_chars;
        logic        ucs2_mode;
        logic [12:0] unit_count;
        logic        rejected;
    } out_t;

    // classified request held in the queue
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] septets;
    } q_item_t;

    // default text length limit in characters
    localparam int MaxCharsDefault = 4095;

    // counter widths and limit
    localparam int UnitW = 13;
    localparam logic [UnitW:0] CountLimit = 14'd8191;

    // queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // segment capacities
    localparam int SegBytes       = 140;
    localparam int ConcatOverhead = 6;
    localparam int CapW           = 8;
    localparam int CapGsmSingle   = (SegBytes * 8) / 7;
    localparam int CapGsmConcat   = ((SegBytes - ConcatOverhead) * 8) / 7;
    localparam int CapUcsSingle   = (SegBytes * 8) / 16;
    localparam int CapUcsConcat   = ((SegBytes - ConcatOverhead) * 8) / 16;

    // reciprocals for the quotient, exact for every count below 2^UnitW
    localparam int RecipShift   = 24;
    localparam int RecipW       = 18;
    localparam int RecipGsmSingle = ((1 << RecipShift) + CapGsmSingle - 1) / CapGsmSingle;
    localparam int RecipGsmConcat = ((1 << RecipShift) + CapGsmConcat - 1) / CapGsmConcat;
    localparam int RecipUcsSingle = ((1 << RecipShift) + CapUcsSingle - 1) / CapUcsSingle;
    localparam int RecipUcsConcat = ((1 << RecipShift) + CapUcsConcat - 1) / CapUcsConcat;

    // gsm 03.38 default alphabet, one septet each
    localparam logic [15:0] BaseTable [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h00A0, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    // extension table, escape plus one septet
    localparam logic [15:0] ExtTable [10] = '{
        16'h000C, 16'h005E, 16'h007B, 16'h007D, 16'h005C,
        16'h005B, 16'h007E, 16'h005D, 16'h007C, 16'h20AC
    };

    // septets for a code unit: 1 base, 2 extension, 0 neither
    function automatic logic [1:0] septets_of(input logic [15:0] u);
        logic hit_base;
        logic hit_ext;
        hit_base = 1'b0;
        hit_ext  = 1'b0;
        for (int i = 0; i < 128; i++) begin
            hit_base = hit_base | (BaseTable[i] == u);
        end
        for (int i = 0; i < 10; i++) begin
            hit_ext = hit_ext | (ExtTable[i] == u);
        end
        if (hit_base) begin
            return 2'd1;
        end else if (hit_ext) begin
            return 2'd2;
        end else begin
            return 2'd0;
        end
    endfunction

endpackage

>>> rtl/core/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// Input side: takes requests and classifies each code unit against the
// character tables before it enters the queue.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  in_t     s_data,
    input  logic    q_full,
    output logic    q_push,
    output q_item_t q_item
);

    // accept whenever the queue has room
    assign s_ready = ~q_full;
    assign q_push  = s_valid & s_ready;

    // classification
    always_comb begin
        q_item.op      = s_data.op;
        q_item.septets = septets_of(s_data.code_unit);
    end

    // queue must never be written while full
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("ssc_front: push into full queue");

endmodule

>>> rtl/core/ssc_fifo.sv
// ----------------------------------------------------------------------------
// ssc_fifo
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module ssc_fifo import ssc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    pop_valid,
    output q_item_t pop_data
);

    q_item_t            mem_reg [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg;
    logic [QPtrW-1:0]   rd_ptr_reg;
    logic [QCntW-1:0]   count_reg;
    logic [QCntW-1:0]   count_next;

    assign full      = (count_reg == QCntW'(QDepth));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCntW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCntW'(QDepth))
        else $error("ssc_fifo: occupancy beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> pop_valid)
        else $error("ssc_fifo: pop from empty queue");

endmodule

>>> rtl/core/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back
// Execution side: applies each request to the counters, then works out the
// segment count and free space over two pipeline stages.
// ----------------------------------------------------------------------------
module ssc_back import ssc_pkg::*; #(
    parameter int MAX_CHARS = MaxCharsDefault
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  q_item_t q_data,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data
);

    localparam logic [16:0] CharLimit = 17'(MAX_CHARS);

    // counter state (stage a)
    logic             ucs2_reg,  ucs2_next;
    logic [UnitW-1:0] unit_reg,  unit_next;
    logic [UnitW-1:0] char_reg,  char_next;
    logic             rej_next;
    logic             a_valid_reg;
    logic             a_rej_reg;

    // quotient stage (stage b)
    logic                  b_valid_reg;
    logic [UnitW-1:0]      b_unit_reg;
    logic [CapW-1:0]       b_cap_reg;
    logic [6:0]            b_q_reg;
    logic                  b_ucs2_reg;
    logic                  b_rej_reg;

    // output register
    logic m_valid_reg;
    out_t m_data_reg;

    // update helpers
    logic [1:0]       need;
    logic [1:0]       rm_need;
    logic [UnitW:0]   new_chars;
    logic [UnitW:0]   new_units;

    // quotient helpers
    logic [CapW-1:0]         cap_sel;
    logic [RecipW-1:0]       recip_sel;
    logic [UnitW+RecipW-1:0] prod;

    // final helpers
    logic [14:0]      qc;
    logic [UnitW-1:0] rem;
    logic             rem_nz;

    logic adv;

    // whole pipeline advances when the output register is empty or being taken
    assign adv     = ~m_valid_reg | m_ready;
    assign q_pop   = q_valid & adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // counter update for the popped request
    always_comb begin
        ucs2_next = ucs2_reg;
        unit_next = unit_reg;
        char_next = char_reg;
        rej_next  = 1'b0;
        need      = ucs2_reg ? 2'd1 : q_data.septets;
        rm_need   = (q_data.septets == 2'd2) ? 2'd2 : 2'd1;
        new_chars = {1'b0, char_reg} + (UnitW+1)'(1);
        new_units = (need == 2'd0) ? new_chars
                                   : {1'b0, unit_reg} + (UnitW+1)'(need);
        case (q_data.op)
            OP_APPEND: begin
                if (({3'b0, new_chars} > CharLimit) || (new_chars > CountLimit)
                        || (new_units > CountLimit)) begin
                    rej_next = 1'b1;
                end else begin
                    unit_next = new_units[UnitW-1:0];
                    char_next = new_chars[UnitW-1:0];
                    if (need == 2'd0) begin
                        ucs2_next = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (ucs2_reg || (char_reg == '0) || (unit_reg < UnitW'(rm_need))) begin
                    rej_next = 1'b1;
                end else begin
                    unit_next = unit_reg - UnitW'(rm_need);
                    char_next = char_reg - UnitW'(1);
                end
            end
            OP_CLEAR: begin
                ucs2_next = 1'b0;
                unit_next = '0;
                char_next = '0;
            end
            default: begin
                rej_next = 1'b1;
            end
        endcase
    end

    // capacity choice and reciprocal multiply
    always_comb begin
        if (ucs2_reg) begin
            if (unit_reg > UnitW'(CapUcsSingle)) begin
                cap_sel   = CapW'(CapUcsConcat);
                recip_sel = RecipW'(RecipUcsConcat);
            end else begin
                cap_sel   = CapW'(CapUcsSingle);
                recip_sel = RecipW'(RecipUcsSingle);
            end
        end else begin
            if (unit_reg > UnitW'(CapGsmSingle)) begin
                cap_sel   = CapW'(CapGsmConcat);
                recip_sel = RecipW'(RecipGsmConcat);
            end else begin
                cap_sel   = CapW'(CapGsmSingle);
                recip_sel = RecipW'(RecipGsmSingle);
            end
        end
        prod = {{RecipW{1'b0}}, unit_reg} * {{UnitW{1'b0}}, recip_sel};
    end

    // remainder, segment count and free space
    always_comb begin
        qc     = {8'b0, b_q_reg} * {7'b0, b_cap_reg};
        rem    = b_unit_reg - qc[UnitW-1:0];
        rem_nz = (rem != '0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ucs2_reg    <= 1'b0;
            unit_reg    <= '0;
            char_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
            if (q_pop) begin
                ucs2_reg <= ucs2_next;
                unit_reg <= unit_next;
                char_reg <= char_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (q_pop) begin
                a_rej_reg <= rej_next;
            end
            b_unit_reg <= unit_reg;
            b_cap_reg  <= cap_sel;
            b_q_reg    <= prod[UnitW+RecipW-1:RecipShift];
            b_ucs2_reg <= ucs2_reg;
            b_rej_reg  <= a_rej_reg;
            m_data_reg.message_count   <= b_q_reg + 7'(rem_nz);
            m_data_reg.remaining_chars <= rem_nz ? (b_cap_reg - rem[CapW-1:0]) : '0;
            m_data_reg.ucs2_mode       <= b_ucs2_reg;
            m_data_reg.unit_count      <= b_unit_reg;
            m_data_reg.rejected        <= b_rej_reg;
        end
    end

    // in ucs2 mode every character is one unit
    assert property (@(posedge aclk) disable iff (!aresetn)
        ucs2_reg |-> (unit_reg == char_reg))
        else $error("ssc_back: ucs2 unit count differs from character count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        {4'b0, char_reg} <= CharLimit)
        else $error("ssc_back: character count above limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.remaining_chars < 8'(CapGsmSingle)))
        else $error("ssc_back: free space beyond segment size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.ucs2_mode)
            |-> (m_data_reg.remaining_chars < 8'(CapUcsSingle)))
        else $error("ssc_back: ucs2 free space beyond segment size");

endmodule

>>> rtl/core/sms_segment_counter.sv
// ----------------------------------------------------------------------------
// sms_segment_counter
// Counts gsm 7-bit septets or ucs-2 characters of an edited text and gives
// the sms segment count and free space after every request.
// ----------------------------------------------------------------------------
// a request passes the queue, stage a and stage b before the output register
// throughput: one request per cycle unless stalled; single-cycle counter loop
// a 4-entry queue between classifier and counter absorbs output back-pressure
// reset: synchronous, active low; clears the queue, pipeline, counters and
// returns to gsm 7-bit mode
module sms_segment_counter import ssc_pkg::*; #(
    parameter int MAX_CHARS = MaxCharsDefault
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic    q_full;
    logic    q_push;
    q_item_t q_push_item;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_pop_item;

    // classifier
    ssc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    // request queue
    ssc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_item)
    );

    // counters and segment arithmetic
    ssc_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_pop_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/sms_segment_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_segment_counter_test
// Self-checking bench for the sms segment counter. Requests go in over a
// valid/ready channel with random gaps while the result side stalls at
// random. A behavioural copy of the counter predicts every result and each
// result field is compared in order. The run has a short directed table
// followed by random editing sessions.
// ----------------------------------------------------------------------------
module sms_segment_counter_test import ssc_pkg::*;;

    localparam int TextLimit    = MaxCharsDefault;
    localparam int CounterMax   = 8191;
    localparam int SegOctets    = 140;
    localparam int HeaderOctets = 6;
    localparam int IdleMax      = 18;
    localparam int RandomItems  = 925;
    localparam int SettleCycles = 8;
    localparam int CycleLimit   = 2000000;

    // op code with no meaning, always refused
    localparam logic [1:0] OpUndefined = 2'd3;

    // gsm 03.38 default alphabet, one septet each
    localparam logic [15:0] GsmBase [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h00A0, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    // extension table, escape plus one septet
    localparam logic [15:0] GsmExt [10] = '{
        16'h000C, 16'h005E, 16'h007B, 16'h007D, 16'h005C,
        16'h005B, 16'h007E, 16'h005D, 16'h007C, 16'h20AC
    };

    // one row of the directed table; pinned rows carry their result
    typedef struct packed {
        in_t  req;
        logic pinned;
        out_t want;
    } dir_row_t;

    localparam int DirCount = 23;
    localparam dir_row_t DirRows [DirCount] = '{
        '{'{OP_REMOVE,  16'h0041}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b1}},
        '{'{OpUndefined, 16'hFFFF}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b1}},
        '{'{OP_APPEND,  16'h0040}, 1'b1, '{7'd1, 8'd159, 1'b0, 13'd1, 1'b0}},
        '{'{OP_REMOVE,  16'h20AC}, 1'b1, '{7'd1, 8'd159, 1'b0, 13'd1, 1'b1}},
        '{'{OP_APPEND,  16'h20AC}, 1'b0, '0},
        '{'{OP_APPEND,  16'h000C}, 1'b0, '0},
        '{'{OP_APPEND,  16'h005E}, 1'b0, '0},
        '{'{OP_APPEND,  16'h00A3}, 1'b0, '0},
        '{'{OP_APPEND,  16'h0394}, 1'b0, '0},
        '{'{OP_APPEND,  16'h00E0}, 1'b0, '0},
        '{'{OP_REMOVE,  16'h00E0}, 1'b0, '0},
        '{'{OP_REMOVE,  16'h005E}, 1'b0, '0},
        '{'{OP_REMOVE,  16'h4E2D}, 1'b0, '0},
        '{'{OP_CLEAR,   16'h0000}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b0}},
        '{'{OP_APPEND,  16'h0000}, 1'b1, '{7'd1, 8'd69,  1'b1, 13'd1, 1'b0}},
        '{'{OP_APPEND,  16'hFFFF}, 1'b0, '0},
        '{'{OP_APPEND,  16'h0041}, 1'b0, '0},
        '{'{OP_REMOVE,  16'h0041}, 1'b0, '0},
        '{'{OP_CLEAR,   16'hFFFF}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b0}},
        '{'{OP_APPEND,  16'h007C}, 1'b0, '0},
        '{'{OP_APPEND,  16'h8000}, 1'b0, '0},
        '{'{OP_CLEAR,   16'h5555}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b0}},
        '{'{OpUndefined, 16'h0000}, 1'b1, '{7'd0, 8'd0,   1'b0, 13'd0, 1'b1}}
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // predicted counter state
    logic ucs2_on    = 1'b0;
    int   unit_tally = 0;
    int   char_tally = 0;

    out_t        pending_counts [$];
    logic [15:0] text_units [$];
    int          errors    = 0;
    int          cycles    = 0;
    int          rx_hold   = 0;
    logic        rx_steady = 1'b0;
    logic        tx_steady = 1'b0;

    sms_segment_counter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // septets a code unit takes: 1 base, 2 extension, 0 neither
    function automatic int septet_cost(logic [15:0] u);
        for (int i = 0; i < 128; i++) begin
            if (GsmBase[i] == u) return 1;
        end
        for (int i = 0; i < 10; i++) begin
            if (GsmExt[i] == u) return 2;
        end
        return 0;
    endfunction

    // apply one request to the predicted state and work out the segment report
    function automatic out_t count_segments(in_t req);
        int   need;
        int   chars_next;
        int   units_next;
        int   bits;
        int   cap;
        int   rem;
        logic ok;
        out_t res;
        ok = 1'b0;
        case (req.op)
            OP_APPEND: begin
                need       = ucs2_on ? 1 : septet_cost(req.code_unit);
                chars_next = char_tally + 1;
                units_next = (need == 0) ? chars_next : unit_tally + need;
                if (chars_next <= TextLimit && chars_next <= CounterMax &&
                        units_next <= CounterMax) begin
                    ok = 1'b1;
                    // first character outside both tables forces ucs-2
                    if (need == 0) ucs2_on = 1'b1;
                    unit_tally = units_next;
                    char_tally = chars_next;
                end
            end
            OP_REMOVE: begin
                need = (septet_cost(req.code_unit) == 2) ? 2 : 1;
                if (!ucs2_on && char_tally != 0 && unit_tally >= need) begin
                    ok = 1'b1;
                    unit_tally -= need;
                    char_tally -= 1;
                end
            end
            OP_CLEAR: begin
                ok         = 1'b1;
                ucs2_on    = 1'b0;
                unit_tally = 0;
                char_tally = 0;
            end
            default: ok = 1'b0;
        endcase
        // single segment capacity, concatenated once it overflows
        bits = ucs2_on ? 16 : 7;
        cap  = (SegOctets * 8) / bits;
        if (unit_tally > cap) cap = ((SegOctets - HeaderOctets) * 8) / bits;
        rem = unit_tally % cap;
        res.message_count   = 7'(unit_tally / cap + ((rem != 0) ? 1 : 0));
        res.remaining_chars = 8'((rem != 0) ? cap - rem : 0);
        res.ucs2_mode       = ucs2_on;
        res.unit_count      = 13'(unit_tally);
        res.rejected        = !ok;
        return res;
    endfunction

    function automatic in_t request(logic [1:0] op, logic [15:0] u);
        in_t r;
        r.op        = op;
        r.code_unit = u;
        return r;
    endfunction

    // mostly base characters, some from the extension table
    function automatic logic [15:0] gsm_char();
        if ($urandom_range(0, 99) < 85) return GsmBase[$urandom_range(0, 127)];
        return GsmExt[$urandom_range(0, 9)];
    endfunction

    function automatic logic [15:0] foreign_char();
        logic [15:0] u;
        do begin
            u = 16'($urandom);
        end while (septet_cost(u) != 0);
        return u;
    endfunction

    // compare a result against the oldest pending expected result
    task automatic check_result(out_t got);
        out_t want;
        if (pending_counts.size() == 0) begin
            $error("result with no request pending: %h", got);
            errors++;
            return;
        end
        want = pending_counts.pop_front();
        if (got.message_count !== want.message_count) begin
            $error("message_count: expected %0d, got %0d", want.message_count,
                   got.message_count);
            errors++;
        end
        if (got.remaining_chars !== want.remaining_chars) begin
            $error("remaining_chars: expected %0d, got %0d", want.remaining_chars,
                   got.remaining_chars);
            errors++;
        end
        if (got.ucs2_mode !== want.ucs2_mode) begin
            $error("ucs2_mode: expected %0d, got %0d", want.ucs2_mode, got.ucs2_mode);
            errors++;
        end
        if (got.unit_count !== want.unit_count) begin
            $error("unit_count: expected %0d, got %0d", want.unit_count, got.unit_count);
            errors++;
        end
        if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
            errors++;
        end
    endtask

    // result side: random stalls, with quiet stretches
    always @(posedge aclk) begin : take_results
        int hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            hold = (rx_hold > 0) ? rx_hold - 1 : 0;
            if (m_valid && m_ready) begin
                check_result(m_data);
                if ($urandom_range(0, 47) == 0) rx_steady = !rx_steady;
                hold = rx_steady ? 0 : $urandom_range(0, IdleMax);
            end
            rx_hold <= hold;
            m_ready <= (hold == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // predict, then offer one request and hold it until taken
    task automatic send_request(in_t req, logic pinned = 1'b0, out_t want = '0);
        int   gap;
        out_t pred;
        pred = count_segments(req);
        if (!pred.rejected) begin
            case (req.op)
                OP_APPEND: text_units.push_back(req.code_unit);
                OP_REMOVE: void'(text_units.pop_back());
                OP_CLEAR:  text_units.delete();
                default:   ;
            endcase
        end
        pending_counts.push_back(pinned ? want : pred);
        if ($urandom_range(0, 47) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, IdleMax);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    // editing sessions: clear, then mostly appends and matching removes
    task automatic run_sessions(int target);
        int sent;
        int span;
        int swap_at;
        int pick;
        sent = 0;
        while (sent < target) begin
            span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30)
                                              : $urandom_range(80, 300);
            swap_at = ($urandom_range(0, 9) < 3) ? $urandom_range(0, span - 1) : -1;
            send_request(request(OP_CLEAR, 16'($urandom)));
            sent++;
            for (int k = 0; k < span && sent < target; k++) begin
                pick = $urandom_range(0, 99);
                if (k == swap_at) begin
                    send_request(request(OP_APPEND, foreign_char()));
                end else if (pick < 72) begin
                    send_request(request(OP_APPEND, gsm_char()));
                end else if (pick < 88) begin
                    send_request(request(OP_REMOVE,
                        (text_units.size() != 0) ? text_units[$] : gsm_char()));
                end else begin
                    send_request(request(2'($urandom_range(0, 3)), 16'($urandom)));
                end
                sent++;
            end
            if (sent > target / 2 && sent - span <= target / 2) drain();
        end
    endtask

    // main sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DirCount; i++) begin
            send_request(DirRows[i].req, DirRows[i].pinned, DirRows[i].want);
        end
        drain();

        run_sessions(RandomItems);

        drain();
        repeat (SettleCycles) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sms_segment_counter.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_front.sv
rtl/core/ssc_fifo.sv
rtl/core/ssc_back.sv
rtl/core/sms_segment_counter.sv
tb/sms_segment_counter_test.sv
